### design/rpmpwm_pkg.sv
// Shared types, codes and the fixed calibration ROM of the RPM to PWM compare interpolator.
`default_nettype none

package rpmpwm_pkg;

   localparam int ROM_ENTRIES = 18;
   localparam int ROM_ADDR_W  = 6;
   localparam int PW_W        = 11;
   localparam int TRPM_W      = 12;

   localparam logic [16:0] COMPARE_MAX = 17'h1FFFF;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BELOW = 2'd1;
   localparam logic [1:0] STATUS_ABOVE = 2'd2;

   localparam logic CSR_TIMER_PERIOD = 1'b0;
   localparam logic CSR_PPM_PERIOD   = 1'b1;

   typedef struct packed {
      logic [PW_W-1:0]   pw;
      logic [TRPM_W-1:0] rpm;
   } cal_entry_type;

   // Entries past the end of the ROM repeat the last point.
   function automatic cal_entry_type cal_rom(input logic [ROM_ADDR_W-1:0] addr);
      cal_entry_type e;
      case (addr)
         6'd0: begin e.pw = 11'd1565; e.rpm = 12'd463; end
         6'd1: begin e.pw = 11'd1567; e.rpm = 12'd500; end
         6'd2: begin e.pw = 11'd1570; e.rpm = 12'd530; end
         6'd3: begin e.pw = 11'd1575; e.rpm = 12'd639; end
         6'd4: begin e.pw = 11'd1580; e.rpm = 12'd745; end
         6'd5: begin e.pw = 11'd1585; e.rpm = 12'd850; end
         6'd6: begin e.pw = 11'd1590; e.rpm = 12'd925; end
         6'd7: begin e.pw = 11'd1595; e.rpm = 12'd1005; end
         6'd8: begin e.pw = 11'd1600; e.rpm = 12'd1105; end
         6'd9: begin e.pw = 11'd1610; e.rpm = 12'd1260; end
         6'd10: begin e.pw = 11'd1650; e.rpm = 12'd1805; end
         6'd11: begin e.pw = 11'd1700; e.rpm = 12'd2224; end
         6'd12: begin e.pw = 11'd1750; e.rpm = 12'd2505; end
         6'd13: begin e.pw = 11'd1800; e.rpm = 12'd2650; end
         6'd14: begin e.pw = 11'd1850; e.rpm = 12'd2784; end
         6'd15: begin e.pw = 11'd1900; e.rpm = 12'd2860; end
         6'd16: begin e.pw = 11'd1950; e.rpm = 12'd2950; end
         default: begin e.pw = 11'd2000; e.rpm = 12'd3085; end
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

### design/rpm_to_pwm_compare_interpolator.sv
// Top level: RPM request to PWM timer compare value by table search, interpolation and scaling.
// The search walks the table one entry per cycle, up to TABLE_ENTRIES entries; then the
// interpolation and the scaling each take a product from the shared multiplier and divide
// it one quotient bit per cycle (27 and 33 dividend bits), the scaling divide skipped for a
// zero frame period, and a final state presents the result. Out-of-range requests skip the
// arithmetic. One item is in flight at a time. Synchronous active-high reset returns the
// sequencer to idle and the two registers to 65536 counts and 20000 us.
`default_nettype none

module rpm_to_pwm_compare_interpolator
   import rpmpwm_pkg::*;
#(
   parameter int TABLE_ENTRIES = 18
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_requested_rpm,
   // Response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [16:0]      rsp_compare_value,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_pulse_width_q4,
   // Register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // The search index never goes past the last entry, so it needs only enough bits to
   // address the table.
   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   // Divide lengths: the interpolation dividend is 27 bits, the scaling dividend 33 bits.
   localparam logic [5:0] DivLenInterp = 6'd27;
   localparam logic [5:0] DivLenScale  = 6'd33;

   // Control state.
   logic [2:0]      state_ff, state_in;
   logic            phase_ff, phase_in;   // 0 interpolation, 1 scaling
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [5:0]      div_cnt_ff, div_cnt_in;
   logic [16:0]     timer_period_ff, timer_period_in;
   logic [15:0]     ppm_period_ff, ppm_period_in;

   // Working and result registers.
   logic [15:0]       rpm_ff, rpm_in;
   cal_entry_type     prev_ff, prev_in;
   logic [TRPM_W-1:0] diff_ff, diff_in;
   logic [PW_W-1:0]   dp_ff, dp_in;
   logic [19:0]       divisor_ff, divisor_in;
   logic [19:0]       rem_ff, rem_in;
   logic [32:0]       quo_ff, quo_in;
   logic [16:0]       cmp_ff, cmp_in;
   logic [1:0]        status_ff, status_in;
   logic [15:0]       pw_ff, pw_in;

   // Shared datapath signals.
   cal_entry_type cur_entry;
   logic          rpm_below;
   logic [15:0]   mul_a;
   logic [16:0]   mul_b;
   logic [32:0]   product;
   logic [20:0]   div_shifted;
   logic [21:0]   div_trial;
   logic          div_fits;
   logic [19:0]   div_rem_next;
   logic [32:0]   div_quo_next;
   logic          csr_write;

   // The calibration table is constant, so the entry under the search index is read straight
   // out of the ROM function.
   assign cur_entry = cal_rom(ROM_ADDR_W'(idx_ff));
   assign rpm_below = rpm_ff < {4'd0, cur_entry.rpm};

   // One multiplier serves both passes: the RPM offset times the pulse-width step for the
   // interpolation, then the pulse width times the timer period for the scaling.
   always_comb begin
      if (phase_ff) begin
         mul_a = pw_ff;
         mul_b = timer_period_ff;
      end else begin
         mul_a = 16'(diff_ff);
         mul_b = 17'(dp_ff);
      end
   end
   assign product = 33'(mul_a) * 33'(mul_b);

   // One restoring divide step per cycle, also shared by both passes. The dividend sits at the
   // top of the quotient register and is shifted out as quotient bits are shifted in.
   assign div_shifted  = {rem_ff, quo_ff[32]};
   assign div_trial    = {1'b0, div_shifted} - {2'd0, divisor_ff};
   assign div_fits     = ~div_trial[21];
   assign div_rem_next = div_fits ? div_trial[19:0] : div_shifted[19:0];
   assign div_quo_next = {quo_ff[31:0], div_fits};

   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      idx_in          = idx_ff;
      div_cnt_in      = div_cnt_ff;
      timer_period_in = timer_period_ff;
      ppm_period_in   = ppm_period_ff;
      rpm_in          = rpm_ff;
      prev_in         = prev_ff;
      diff_in         = diff_ff;
      dp_in           = dp_ff;
      divisor_in      = divisor_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      cmp_in          = cmp_ff;
      status_in       = status_ff;
      pw_in           = pw_ff;

      // Register writes; software must make them only while idle, unchecked by the block.
      if (csr_write) begin
         if (csr_paddr[2] == CSR_TIMER_PERIOD) begin
            timer_period_in = csr_pwdata[16:0];
         end else begin
            ppm_period_in = csr_pwdata[15:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rpm_in   = req_requested_rpm;
               idx_in   = '0;
               phase_in = 1'b0;
               state_in = ST_SEARCH;
            end
         end

         // Walk the table one entry a cycle for the first RPM above the request, else flag out of range.
         ST_SEARCH: begin
            if (idx_ff == '0) begin
               if (rpm_below) begin
                  cmp_in    = '0;
                  pw_in     = '0;
                  status_in = STATUS_BELOW;
                  state_in  = ST_OUT;
               end else begin
                  prev_in = cur_entry;
                  idx_in  = idx_ff + 1'b1;
               end
            end else if (rpm_below) begin
               // The request lies at or above the previous point, so this difference fits.
               diff_in    = rpm_ff[TRPM_W-1:0] - prev_ff.rpm;
               dp_in      = (cur_entry.pw >= prev_ff.pw) ? (cur_entry.pw - prev_ff.pw) : '0;
               divisor_in = 20'(cur_entry.rpm - prev_ff.rpm);
               state_in   = ST_MUL;
            end else if (idx_ff == LastIdx) begin
               cmp_in    = '0;
               pw_in     = '0;
               status_in = STATUS_ABOVE;
               state_in  = ST_OUT;
            end else begin
               prev_in = cur_entry;
               idx_in  = idx_ff + 1'b1;
            end
         end

         // Load the product as dividend for this pass's divide; a zero frame period saturates.
         ST_MUL: begin
            rem_in = '0;
            if (!phase_ff) begin
               quo_in     = {product[22:0], 4'd0, 6'd0};
               div_cnt_in = DivLenInterp;
               state_in   = ST_DIV;
            end else if (ppm_period_ff == '0) begin
               cmp_in    = COMPARE_MAX;
               status_in = STATUS_OK;
               state_in  = ST_OUT;
            end else begin
               quo_in     = product;
               divisor_in = {ppm_period_ff, 4'd0};
               div_cnt_in = DivLenScale;
               state_in   = ST_DIV;
            end
         end

         ST_DIV: begin
            rem_in     = div_rem_next;
            quo_in     = div_quo_next;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == 6'd1) begin
               if (!phase_ff) begin
                  // The fraction never exceeds the step times sixteen, so 16 bits suffice.
                  pw_in    = 16'({prev_ff.pw, 4'd0}) + div_quo_next[15:0];
                  phase_in = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  cmp_in    = (div_quo_next[32:17] != '0) ? COMPARE_MAX : div_quo_next[16:0];
                  status_in = STATUS_OK;
                  state_in  = ST_OUT;
               end
            end
         end

         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         phase_ff        <= 1'b0;
         idx_ff          <= '0;
         div_cnt_ff      <= '0;
         timer_period_ff <= 17'h10000;
         ppm_period_ff   <= 16'd20000;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         idx_ff          <= idx_in;
         div_cnt_ff      <= div_cnt_in;
         timer_period_ff <= timer_period_in;
         ppm_period_ff   <= ppm_period_in;
      end
   end

   always_ff @(posedge clock) begin
      rpm_ff     <= rpm_in;
      prev_ff    <= prev_in;
      diff_ff    <= diff_in;
      dp_ff      <= dp_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cmp_ff     <= cmp_in;
      status_ff  <= status_in;
      pw_ff      <= pw_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = (state_ff == ST_OUT);
   assign rsp_compare_value  = cmp_ff;
   assign rsp_status         = status_ff;
   assign rsp_pulse_width_q4 = pw_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_TIMER_PERIOD) ? {15'd0, timer_period_ff}
                                                          : {16'd0, ppm_period_ff};

   // The block never takes a request while a result is still on offer.
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request accepted while a result is pending");

   // An accepted request always starts the search on the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SEARCH) && (idx_ff == '0))
      else $error("accepted request did not start the search");

   // Out-of-range results carry neither a pulse width nor a compare value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_BELOW || rsp_status == STATUS_ABOVE)) |->
      (rsp_compare_value == '0) && (rsp_pulse_width_q4 == '0))
      else $error("out-of-range result with non-zero payload");

   // Only the three defined status codes are ever reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_BELOW ||
                     rsp_status == STATUS_ABOVE))
      else $error("undefined status code on the response");

endmodule

`default_nettype wire

### verif/compare_value_checker.sv
`timescale 1ns / 100ps
// Checker that predicts and compares the compare value, status and pulse width of each request.
module compare_value_checker
   import rpmpwm_pkg::*;
#(
   parameter int TABLE_ENTRIES = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_requested_rpm,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [16:0] rsp_compare_value,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_pulse_width_q4,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          outstanding
);

   localparam int ROM_POINTS = 18;

   typedef struct packed {
      logic [16:0] compare_value;
      logic [1:0]  status;
      logic [15:0] pulse_width_q4;
   } setpoint_type;

   // Calibration points: pulse width in microseconds against speed in RPM.
   int unsigned cal_pw [ROM_POINTS] = '{1565, 1567, 1570, 1575, 1580, 1585, 1590, 1595, 1600,
                                        1610, 1650, 1700, 1750, 1800, 1850, 1900, 1950, 2000};
   int unsigned cal_rpm [ROM_POINTS] = '{463, 500, 530, 639, 745, 850, 925, 1005, 1105,
                                         1260, 1805, 2224, 2505, 2650, 2784, 2860, 2950, 3085};

   logic [16:0]  timer_counts;
   logic [15:0]  frame_us;
   setpoint_type pending_setpoints [$];
   int           errors = 0;

   function automatic longint unsigned point_pw(input int k);
      return cal_pw[(k < ROM_POINTS) ? k : ROM_POINTS - 1];
   endfunction

   function automatic longint unsigned point_rpm(input int k);
      return cal_rpm[(k < ROM_POINTS) ? k : ROM_POINTS - 1];
   endfunction

   function automatic setpoint_type interpolate_setpoint(input logic [15:0] rpm);
      setpoint_type      r;
      int                hit;
      longint unsigned   speed, p0, p1, r0, r1, span, pw, quot;
      r     = '0;
      hit   = -1;
      speed = rpm;
      if (speed < point_rpm(0)) begin
         r.status = STATUS_BELOW;
      end else begin
         for (int k = 1; k < TABLE_ENTRIES; k++) begin
            if (hit < 0 && speed < point_rpm(k)) hit = k;
         end
         if (hit < 0) begin
            r.status = STATUS_ABOVE;
         end else begin
            p0   = point_pw(hit - 1);
            p1   = point_pw(hit);
            r0   = point_rpm(hit - 1);
            r1   = point_rpm(hit);
            span = (p1 >= p0) ? p1 - p0 : 0;
            pw   = p0 * 16;
            if (r1 > r0) pw = pw + ((speed - r0) * span * 16) / (r1 - r0);
            pw = pw & 64'hFFFF;
            if (frame_us == 0) begin
               quot = COMPARE_MAX;
            end else begin
               quot = (pw * timer_counts) / (longint'(frame_us) * 16);
               if (quot > COMPARE_MAX) quot = COMPARE_MAX;
            end
            r.status         = STATUS_OK;
            r.pulse_width_q4 = pw[15:0];
            r.compare_value  = quot[16:0];
         end
      end
      return r;
   endfunction

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      setpoint_type want;
      if (reset) begin
         timer_counts = 17'd65536;
         frame_us     = 16'd20000;
         pending_setpoints.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_TIMER_PERIOD) timer_counts = csr_pwdata[16:0];
            else frame_us = csr_pwdata[15:0];
         end
         if (req_valid && req_ready)
            pending_setpoints.push_back(interpolate_setpoint(req_requested_rpm));
         if (rsp_valid && rsp_ready) begin
            if (pending_setpoints.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, expected none, got compare %0d status %0d pw %0d",
                        $time, rsp_compare_value, rsp_status, rsp_pulse_width_q4);
            end else begin
               want = pending_setpoints.pop_front();
               check_field("compare_value", want.compare_value, rsp_compare_value);
               check_field("status", want.status, rsp_status);
               check_field("pulse_width_q4", want.pulse_width_q4, rsp_pulse_width_q4);
            end
         end
      end
      mismatches  <= errors;
      outstanding <= pending_setpoints.size();
   end

endmodule

### verif/tb_rpm_to_pwm_compare_interpolator.sv
`timescale 1ns / 100ps
// Testbench top: stimulus, register programming and verdict for the RPM to compare interpolator.
module tb_rpm_to_pwm_compare_interpolator
   import rpmpwm_pkg::*;
();

   // The calibration table size used by both the block and the checker.
   localparam int CAL_POINTS = 18;
   // Register byte addresses, one 32-bit word per register.
   localparam logic [2:0] ADDR_TIMER_PERIOD = {CSR_TIMER_PERIOD, 2'b00};
   localparam logic [2:0] ADDR_PPM_PERIOD   = {CSR_PPM_PERIOD, 2'b00};
   // Random items per register setting, and in the opening setting after the directed items.
   localparam int PHASE_ITEMS   = 125;
   localparam int OPENING_ITEMS = 150;
   // The receiver holds off once, after this many items, for this many cycles.
   localparam int HOLD_AFTER  = 400;
   localparam int HOLD_CYCLES = 600;
   // The long hold-off dominates the quiet limit.
   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_requested_rpm = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [16:0] rsp_compare_value;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_pulse_width_q4;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int  mismatches;
   int  outstanding;
   int  items_accepted = 0;
   int  quiet_cycles = 0;
   bit  calm = 1'b0;
   bit  hold_done = 1'b0;

   rpm_to_pwm_compare_interpolator #(.TABLE_ENTRIES(CAL_POINTS)) dut (.*);

   compare_value_checker #(.TABLE_ENTRIES(CAL_POINTS)) compare_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_requested_rpm,
      .rsp_valid, .rsp_ready, .rsp_compare_value, .rsp_status, .rsp_pulse_width_q4,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatches, .outstanding
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Reset is held at the start and then released for good.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Count accepted requests, and watch for the run going quiet. Any handshake on either
   // channel, or a register access, counts as progress.
   always @(posedge clock) begin
      if (req_valid && req_ready) items_accepted <= items_accepted + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_rpm_to_pwm_compare_interpolator: errors");
            $finish;
         end
      end
   end

   // Result side. Normally ready drops in about a quarter of the cycles, and never during the
   // calm setting. Once, well into the run, the receiver stops taking results for a long while
   // so that the block holds its result and has to refuse further requests.
   initial begin
      forever begin
         @(posedge clock);
         if (!hold_done && items_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99) >= 27);
      end
   end

   // Offers one speed request and returns at the edge at which it is taken. Valid is only
   // lowered while idling, so back-to-back items keep it high without a glitch.
   task automatic offer_speed(input logic [15:0] rpm);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_requested_rpm <= rpm;
      do @(posedge clock); while (!req_ready);
   endtask

   // Most random speeds fall inside the table, where the interpolation does its work; the rest
   // sit just around either end or anywhere in the 16-bit range.
   function automatic logic [15:0] random_speed();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return 16'($urandom_range(3084, 463));
      if (roll < 80) return 16'($urandom_range(462, 0));
      if (roll < 88) return 16'($urandom_range(3200, 3000));
      return 16'($urandom());
   endfunction

   // Stops offering and waits until every result expected so far has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // One register write: a setup phase, then an access phase held until pready.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Programs both registers with the block idle, then runs a batch of random requests.
   task automatic run_setting(input logic [31:0] timer_word, input logic [31:0] ppm_word);
      write_register(ADDR_TIMER_PERIOD, timer_word);
      write_register(ADDR_PPM_PERIOD, ppm_word);
      for (int n = 0; n < PHASE_ITEMS; n++) offer_speed(random_speed());
      drain_results();
   endtask

   initial begin
      logic [15:0] directed [$];
      @(posedge clock);
      while (reset) @(posedge clock);

      // Directed items under the reset register values: both ends of the 16-bit range, just
      // below the first point, every calibration point exactly (the last one is already above
      // range), just below the last point and one value inside an interval.
      directed = '{16'd0, 16'd462, 16'd463, 16'd500, 16'd530, 16'd639, 16'd745, 16'd850,
                   16'd925, 16'd1005, 16'd1105, 16'd1260, 16'd1805, 16'd2224, 16'd2505,
                   16'd2650, 16'd2784, 16'd2860, 16'd2950, 16'd3085, 16'd3084, 16'd65535,
                   16'd1000};
      foreach (directed[i]) offer_speed(directed[i]);
      for (int n = 0; n < OPENING_ITEMS; n++) offer_speed(random_speed());
      drain_results();

      // Fewest counts against the longest frame: compare values close to zero.
      run_setting(32'd1, 32'd65535);
      // Widest timer against a one-microsecond frame: the quotient saturates.
      run_setting(32'h0001_FFFF, 32'd1);
      // A zero frame period saturates every in-range result.
      run_setting(32'd65536, 32'd0);
      // A zero timer period gives zero compare values with a valid pulse width.
      run_setting(32'd0, 32'd20000);
      // Back to the usual setting, with neither side idling at all.
      calm = 1'b1;
      run_setting(32'd65536, 32'd20000);
      calm = 1'b0;
      // Random settings, with junk above the register widths that must be dropped.
      repeat (4) run_setting($urandom(), $urandom());

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_rpm_to_pwm_compare_interpolator: clean");
      end else begin
         $display("tb_rpm_to_pwm_compare_interpolator: errors");
      end
      $finish;
   end

endmodule
